// ----- src/glq_pkg.sv -----
// ----------------------------------------------------------------------------
// glq_pkg: shared types and constants of the glyph quad layout block
// Register indexes, character and result codes, sequencer state and the
// control and status words passed between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package glq_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int ATLAS_BITS     = 15;
    localparam int GLYPH_BITS     = 10;
    localparam int ATLAS_IN_BITS  = 17;
    localparam int TEX_OUT_BITS   = 18;
    localparam int VIDX_BITS      = 3;

    localparam longint TEX_OUT_MAX = 262143;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_START_X      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_START_Y      = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LINE_HEIGHT  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ASCENDER     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ATLAS_WIDTH  = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ATLAS_HEIGHT = 3'd5;

    localparam logic [VIDX_BITS-1:0] LAST_VERTEX = 3'd5;

    typedef enum logic [1:0] {
        KIND_GLYPH   = 2'd0,
        KIND_SPACE   = 2'd1,
        KIND_NEWLINE = 2'd2,
        KIND_MARK    = 2'd3
    } char_kind_t;

    typedef enum logic {
        RES_VERTEX = 1'b0,
        RES_BOUNDS = 1'b1
    } result_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV_U,
        ST_DIV_V,
        ST_EMIT,
        ST_BOUNDS
    } seq_state_t;

    typedef struct packed {
        logic lh_zero;
        logic is_glyph;
        logic last;
        logic out_free;
        logic div_done;
    } seq_status_t;

    typedef struct packed {
        logic                 accept;
        logic                 calc;
        logic                 div_start;
        logic                 div_sel_v;
        logic                 load_u1;
        logic                 load_v1;
        logic                 emit_load;
        logic                 bounds_load;
        logic [VIDX_BITS-1:0] vidx;
    } seq_ctrl_t;

endpackage

// ----- src/glq_div.sv -----
// ----------------------------------------------------------------------------
// glq_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, shared by the u and v
// texcoord offsets. The quotient is valid when done pulses.
// ----------------------------------------------------------------------------
module glq_div #(
    parameter int DW = 27
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [DW-1:0]                    num,
    input  logic [glq_pkg::ATLAS_BITS-1:0]   den,
    output logic                             done,
    output logic [DW-1:0]                    quo
);
    import glq_pkg::*;

    localparam int CW = $clog2(DW);

    logic [ATLAS_BITS-1:0] rem_reg;
    logic [ATLAS_BITS-1:0] den_reg;
    logic [DW-1:0]         quo_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [ATLAS_BITS:0]   trial;
    logic [ATLAS_BITS+1:0] diff;

    // The dividend shifts out of the top of quo_reg while quotient bits
    // shift in at the bottom.
    assign trial = {rem_reg, quo_reg[DW-1]};
    assign diff  = {1'b0, trial} - {2'b00, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= den;
            quo_reg <= num;
        end
        else if (busy_reg)
        begin
            if (!diff[ATLAS_BITS+1])
            begin
                rem_reg <= diff[ATLAS_BITS-1:0];
                quo_reg <= {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[ATLAS_BITS-1:0];
                quo_reg <= {quo_reg[DW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ----- src/glq_seq.sv -----
// ----------------------------------------------------------------------------
// glq_seq: sequencer of the glyph quad layout block
// Steps one character through layout, then for a glyph (line height not zero)
// two texcoord divisions and six vertex words; the last adds the bounds word.
// ----------------------------------------------------------------------------
module glq_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  glq_pkg::seq_status_t  status,
    output glq_pkg::seq_ctrl_t    ctrl
);
    import glq_pkg::*;

    seq_state_t           state_reg;
    seq_state_t           state_next;
    logic [VIDX_BITS-1:0] vidx_reg;
    logic [VIDX_BITS-1:0] vidx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            vidx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            vidx_reg  <= vidx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        vidx_next  = vidx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (!status.lh_zero && status.is_glyph)
                begin
                    state_next = ST_DIV_U;
                end
                else if (status.last)
                begin
                    state_next = ST_BOUNDS;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV_U:
            begin
                if (status.div_done)
                begin
                    state_next = ST_DIV_V;
                end
            end
            ST_DIV_V:
            begin
                if (status.div_done)
                begin
                    state_next = ST_EMIT;
                    vidx_next  = '0;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    if (vidx_reg == LAST_VERTEX)
                    begin
                        state_next = status.last ? ST_BOUNDS : ST_IDLE;
                    end
                    else
                    begin
                        vidx_next = vidx_reg + 1'b1;
                    end
                end
            end
            ST_BOUNDS:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready         = (state_reg == ST_IDLE);
        ctrl.accept      = (state_reg == ST_IDLE) && in_valid;
        ctrl.calc        = (state_reg == ST_CALC);
        ctrl.div_start   = ((state_reg == ST_CALC) && !status.lh_zero && status.is_glyph)
                           || ((state_reg == ST_DIV_U) && status.div_done);
        ctrl.div_sel_v   = (state_reg == ST_DIV_U);
        ctrl.load_u1     = (state_reg == ST_DIV_U) && status.div_done;
        ctrl.load_v1     = (state_reg == ST_DIV_V) && status.div_done;
        ctrl.emit_load   = (state_reg == ST_EMIT) && status.out_free;
        ctrl.bounds_load = (state_reg == ST_BOUNDS) && status.out_free;
        ctrl.vidx        = vidx_reg;
    end

endmodule

// ----- src/glyph_quad_layout_top.sv -----
// ----------------------------------------------------------------------------
// glyph_quad_layout_top: text glyph quad layout
// The one-bit-per-cycle divider is run once for u and once for v for a
// glyph; one character is worked on at a time.
// Reset clears the sequencer, the string state and the output valid flag,
// and loads the registers with their defaults (atlas size 1024 by 1024).
// ----------------------------------------------------------------------------
module glyph_quad_layout_top #(
    parameter int COORD_BITS    = 16,
    parameter int TEX_FRAC_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [glq_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [glq_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           char_kind,
    input  logic signed [10:0]                   bearing_x,
    input  logic signed [10:0]                   bearing_y,
    input  logic [9:0]                           glyph_w,
    input  logic [9:0]                           glyph_h,
    input  logic [16:0]                          atlas_u,
    input  logic [16:0]                          atlas_v,
    input  logic signed [10:0]                   advance_x,
    input  logic signed [10:0]                   advance_y,
    input  logic                                 last_char,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 result_kind,
    output logic signed [15:0]                   pos_x,
    output logic signed [15:0]                   pos_y,
    output logic [17:0]                          tex_u,
    output logic [17:0]                          tex_v,
    output logic [15:0]                          box_width,
    output logic [15:0]                          box_height,
    output logic                                 last_result
);
    import glq_pkg::*;

    localparam int SW = ((COORD_BITS > 17) ? COORD_BITS : 17) + 3;
    localparam int DW = TEX_FRAC_BITS + 11;
    localparam int CB = COORD_BITS;

    localparam longint C_MAX_L   = (longint'(1) <<< (CB - 1)) - 1;
    localparam longint TEX_TOP_L = longint'(1) <<< (TEX_FRAC_BITS + 1);
    localparam longint TEX_LIM_L = (TEX_TOP_L > TEX_OUT_MAX) ? TEX_OUT_MAX : TEX_TOP_L;

    localparam logic signed [SW-1:0] C_MAX    = SW'(C_MAX_L);
    localparam logic signed [SW-1:0] C_MIN    = SW'(-C_MAX_L - 1);
    localparam logic signed [SW-1:0] P16_MAX  = SW'(32767);
    localparam logic signed [SW-1:0] P16_MIN  = SW'(-32768);
    localparam logic signed [SW-1:0] SPAN_MAX = SW'(65535);
    localparam logic [DW:0]          TEX_LIM  = (DW + 1)'(TEX_LIM_L);

    function automatic logic signed [CB-1:0] sat_c(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        if (v > C_MAX)
            r = C_MAX;
        else if (v < C_MIN)
            r = C_MIN;
        else
            r = v;
        return r[CB-1:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [CB-1:0] v);
        logic signed [SW-1:0] e;
        logic signed [SW-1:0] r;
        e = SW'(v);
        if (e > P16_MAX)
            r = P16_MAX;
        else if (e < P16_MIN)
            r = P16_MIN;
        else
            r = e;
        return r[15:0];
    endfunction

    function automatic logic [15:0] span16(input logic signed [CB-1:0] hi,
                                           input logic signed [CB-1:0] lo);
        logic signed [SW-1:0] d;
        logic signed [SW-1:0] r;
        d = SW'(hi) - SW'(lo);
        if (d < 0)
            r = '0;
        else if (d > SPAN_MAX)
            r = SPAN_MAX;
        else
            r = d;
        return r[15:0];
    endfunction

    function automatic logic [TEX_OUT_BITS-1:0] tex_sum(input logic [ATLAS_IN_BITS-1:0] a,
                                                        input logic [DW-1:0] q);
        logic [DW:0] s;
        s = (DW + 1)'(a) + (DW + 1)'(q);
        if (s > TEX_LIM)
            s = TEX_LIM;
        return s[TEX_OUT_BITS-1:0];
    endfunction

    // Configuration registers
    logic signed [15:0]    start_x_reg;
    logic signed [15:0]    start_y_reg;
    logic [15:0]           line_height_reg;
    logic signed [12:0]    ascender_reg;
    logic [ATLAS_BITS-1:0] atlas_w_reg;
    logic [ATLAS_BITS-1:0] atlas_h_reg;

    // Latched input word
    char_kind_t               kind_reg;
    logic signed [10:0]       bx_reg;
    logic signed [10:0]       by_reg;
    logic [GLYPH_BITS-1:0]    gw_reg;
    logic [GLYPH_BITS-1:0]    gh_reg;
    logic [ATLAS_IN_BITS-1:0] au_reg;
    logic [ATLAS_IN_BITS-1:0] av_reg;
    logic signed [10:0]       ax_reg;
    logic signed [10:0]       ay_reg;
    logic                     last_reg;

    // String state
    logic signed [CB-1:0] pen_x_reg, pen_x_next;
    logic signed [CB-1:0] pen_y_reg, pen_y_next;
    logic signed [CB-1:0] box_min_x_reg, box_min_x_next;
    logic signed [CB-1:0] box_max_x_reg, box_max_x_next;
    logic signed [CB-1:0] box_min_y_reg, box_min_y_next;
    logic signed [CB-1:0] box_max_y_reg, box_max_y_next;
    logic                 seen_first_reg, seen_first_next;

    // Quad corners and texcoords of the current glyph
    logic signed [CB-1:0]    quad_l_reg;
    logic signed [CB-1:0]    quad_r_reg;
    logic signed [CB-1:0]    quad_t_reg;
    logic signed [CB-1:0]    quad_b_reg;
    logic [TEX_OUT_BITS-1:0] u1_reg;
    logic [TEX_OUT_BITS-1:0] v1_reg;
    logic                    zero_bounds_reg;

    // Output word
    logic                    out_valid_reg;
    result_kind_t            out_kind_reg;
    logic signed [15:0]      out_x_reg;
    logic signed [15:0]      out_y_reg;
    logic [TEX_OUT_BITS-1:0] out_u_reg;
    logic [TEX_OUT_BITS-1:0] out_v_reg;
    logic [15:0]             out_w_reg;
    logic [15:0]             out_h_reg;
    logic                    out_last_reg;

    seq_status_t status;
    seq_ctrl_t   ctrl;

    logic                  lh_zero;
    logic [ATLAS_BITS-1:0] aw_eff;
    logic [ATLAS_BITS-1:0] ah_eff;
    logic [ATLAS_BITS-1:0] div_den;
    logic [GLYPH_BITS-1:0] div_size;
    logic [DW-1:0]         div_num;
    logic [DW-1:0]         div_quo;
    logic                  div_done;

    logic signed [CB-1:0] sx_sat, sy_sat, ep_x, ep_y;
    logic signed [SW-1:0] ep_x_w, ep_y_w, bx_w, by_w, gw_w, gh_w, ax_w, ay_w;
    logic signed [SW-1:0] asc_w, lh_w;
    logic signed [CB-1:0] lx, rx, ty, byy, reach, px_adv, py_adv, py_nl;
    logic signed [CB-1:0] base_min_x, base_max_x, base_min_y, base_max_y;

    logic signed [CB-1:0]    vert_x, vert_y;
    logic [TEX_OUT_BITS-1:0] vert_u, vert_v;

    assign lh_zero = (line_height_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg     <= '0;
            start_y_reg     <= '0;
            line_height_reg <= '0;
            ascender_reg    <= '0;
            atlas_w_reg     <= ATLAS_BITS'(1024);
            atlas_h_reg     <= ATLAS_BITS'(1024);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_X:      start_x_reg     <= cfg_data;
                CFG_START_Y:      start_y_reg     <= cfg_data;
                CFG_LINE_HEIGHT:  line_height_reg <= cfg_data;
                CFG_ASCENDER:     ascender_reg    <= cfg_data[12:0];
                CFG_ATLAS_WIDTH:  atlas_w_reg     <= cfg_data[ATLAS_BITS-1:0];
                CFG_ATLAS_HEIGHT: atlas_h_reg     <= cfg_data[ATLAS_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            kind_reg <= char_kind_t'(char_kind);
            bx_reg   <= bearing_x;
            by_reg   <= bearing_y;
            gw_reg   <= glyph_w;
            gh_reg   <= glyph_h;
            au_reg   <= atlas_u;
            av_reg   <= atlas_v;
            ax_reg   <= advance_x;
            ay_reg   <= advance_y;
            last_reg <= last_char;
        end
    end

    // Layout arithmetic. The first character of a string works from the start
    // position and seeds the box with its own quad, whatever its kind.
    assign sx_sat = sat_c(SW'(start_x_reg));
    assign sy_sat = sat_c(SW'(start_y_reg));
    assign ep_x   = seen_first_reg ? pen_x_reg : sx_sat;
    assign ep_y   = seen_first_reg ? pen_y_reg : sy_sat;

    assign ep_x_w = SW'(ep_x);
    assign ep_y_w = SW'(ep_y);
    assign bx_w   = SW'(bx_reg);
    assign by_w   = SW'(by_reg);
    assign gw_w   = SW'({1'b0, gw_reg});
    assign gh_w   = SW'({1'b0, gh_reg});
    assign ax_w   = SW'(ax_reg);
    assign ay_w   = SW'(ay_reg);
    assign asc_w  = SW'(ascender_reg);
    assign lh_w   = SW'({1'b0, line_height_reg});

    assign lx     = sat_c(ep_x_w + bx_w);
    assign rx     = sat_c(ep_x_w + bx_w + gw_w);
    assign ty     = sat_c(ep_y_w + asc_w - by_w);
    assign byy    = sat_c(ep_y_w + asc_w + gh_w - by_w);
    assign reach  = sat_c(ep_x_w + bx_w + ax_w);
    assign px_adv = sat_c(ep_x_w + ax_w);
    assign py_adv = sat_c(ep_y_w + ay_w);
    assign py_nl  = sat_c(ep_y_w + lh_w);

    assign base_min_x = seen_first_reg ? box_min_x_reg : lx;
    assign base_max_x = seen_first_reg ? box_max_x_reg : rx;
    assign base_min_y = seen_first_reg ? box_min_y_reg : ty;
    assign base_max_y = seen_first_reg ? box_max_y_reg : byy;

    always_comb
    begin
        pen_x_next     = ep_x;
        pen_y_next     = ep_y;
        box_min_x_next = base_min_x;
        box_max_x_next = base_max_x;
        box_min_y_next = base_min_y;
        box_max_y_next = base_max_y;
        unique case (kind_reg)
            KIND_GLYPH:
            begin
                box_min_x_next = (lx < base_min_x) ? lx : base_min_x;
                box_max_x_next = (rx > base_max_x) ? rx : base_max_x;
                box_min_y_next = (ty < base_min_y) ? ty : base_min_y;
                box_max_y_next = (byy > base_max_y) ? byy : base_max_y;
                pen_x_next     = px_adv;
                pen_y_next     = py_adv;
            end
            KIND_SPACE:
            begin
                box_max_x_next = (reach > base_max_x) ? reach : base_max_x;
                pen_x_next     = px_adv;
            end
            KIND_NEWLINE:
            begin
                pen_x_next = sx_sat;
                pen_y_next = py_nl;
            end
            KIND_MARK:
            begin
                pen_x_next = ep_x;
            end
            default:
            begin
                pen_x_next = ep_x;
            end
        endcase

        if (lh_zero)
            seen_first_next = seen_first_reg && !last_reg;
        else
            seen_first_next = !last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg      <= '0;
            pen_y_reg      <= '0;
            box_min_x_reg  <= '0;
            box_max_x_reg  <= '0;
            box_min_y_reg  <= '0;
            box_max_y_reg  <= '0;
            seen_first_reg <= 1'b0;
        end
        else if (ctrl.calc)
        begin
            seen_first_reg <= seen_first_next;
            if (!lh_zero)
            begin
                pen_x_reg     <= pen_x_next;
                pen_y_reg     <= pen_y_next;
                box_min_x_reg <= box_min_x_next;
                box_max_x_reg <= box_max_x_next;
                box_min_y_reg <= box_min_y_next;
                box_max_y_reg <= box_max_y_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.calc)
        begin
            quad_l_reg      <= lx;
            quad_r_reg      <= rx;
            quad_t_reg      <= ty;
            quad_b_reg      <= byy;
            zero_bounds_reg <= lh_zero;
        end
        if (ctrl.load_u1)
            u1_reg <= tex_sum(au_reg, div_quo);
        if (ctrl.load_v1)
            v1_reg <= tex_sum(av_reg, div_quo);
    end

    // Texcoord offset: size * 2^TEX_FRAC_BITS / atlas, rounded half up.
    // An atlas size of zero counts as one.
    assign aw_eff   = (atlas_w_reg == '0) ? ATLAS_BITS'(1) : atlas_w_reg;
    assign ah_eff   = (atlas_h_reg == '0) ? ATLAS_BITS'(1) : atlas_h_reg;
    assign div_den  = ctrl.div_sel_v ? ah_eff : aw_eff;
    assign div_size = ctrl.div_sel_v ? gh_reg : gw_reg;
    assign div_num  = DW'({div_size, {TEX_FRAC_BITS{1'b0}}})
                      + DW'(div_den[ATLAS_BITS-1:1]);

    glq_div #(
        .DW (DW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctrl.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign status.lh_zero  = lh_zero;
    assign status.is_glyph = (kind_reg == KIND_GLYPH);
    assign status.last     = last_reg;
    assign status.out_free = !out_valid_reg || out_ready;
    assign status.div_done = div_done;

    glq_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .ctrl     (ctrl)
    );

    // Corner order: bottom-left, bottom-right, top-right, top-right,
    // top-left, bottom-left.
    always_comb
    begin
        unique case (ctrl.vidx)
            3'd0:
            begin
                vert_x = quad_l_reg; vert_y = quad_b_reg;
                vert_u = TEX_OUT_BITS'(au_reg); vert_v = v1_reg;
            end
            3'd1:
            begin
                vert_x = quad_r_reg; vert_y = quad_b_reg;
                vert_u = u1_reg; vert_v = v1_reg;
            end
            3'd2, 3'd3:
            begin
                vert_x = quad_r_reg; vert_y = quad_t_reg;
                vert_u = u1_reg; vert_v = TEX_OUT_BITS'(av_reg);
            end
            3'd4:
            begin
                vert_x = quad_l_reg; vert_y = quad_t_reg;
                vert_u = TEX_OUT_BITS'(au_reg); vert_v = TEX_OUT_BITS'(av_reg);
            end
            default:
            begin
                vert_x = quad_l_reg; vert_y = quad_b_reg;
                vert_u = TEX_OUT_BITS'(au_reg); vert_v = v1_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.emit_load || ctrl.bounds_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit_load)
        begin
            out_kind_reg <= RES_VERTEX;
            out_x_reg    <= sat16(vert_x);
            out_y_reg    <= sat16(vert_y);
            out_u_reg    <= vert_u;
            out_v_reg    <= vert_v;
            out_w_reg    <= '0;
            out_h_reg    <= '0;
            out_last_reg <= (ctrl.vidx == LAST_VERTEX) && !last_reg;
        end
        else if (ctrl.bounds_load)
        begin
            out_kind_reg <= RES_BOUNDS;
            out_u_reg    <= '0;
            out_v_reg    <= '0;
            out_last_reg <= 1'b1;
            if (zero_bounds_reg)
            begin
                out_x_reg <= '0;
                out_y_reg <= '0;
                out_w_reg <= '0;
                out_h_reg <= '0;
            end
            else
            begin
                out_x_reg <= sat16(box_min_x_reg);
                out_y_reg <= sat16(box_min_y_reg);
                out_w_reg <= span16(box_max_x_reg, box_min_x_reg);
                out_h_reg <= span16(box_max_y_reg, box_min_y_reg);
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = out_kind_reg;
    assign pos_x       = out_x_reg;
    assign pos_y       = out_y_reg;
    assign tex_u       = out_u_reg;
    assign tex_v       = out_v_reg;
    assign box_width   = out_w_reg;
    assign box_height  = out_h_reg;
    assign last_result = out_last_reg;

endmodule
